// File: rtl/fpa_pkg.sv
`timescale 1ns / 1ps

package fpa_pkg;

    // operation codes
    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_DIV   = 4'd3,
        OP_IDIV  = 4'd4,
        OP_MOD   = 4'd5,
        OP_FLOOR = 4'd6,
        OP_CEIL  = 4'd7,
        OP_ROUND = 4'd8,
        OP_ABS   = 4'd9,
        OP_NEG   = 4'd10,
        OP_SIGN  = 4'd11
    } op_t;

    // request beat
    typedef struct packed {
        logic [3:0]         req_type;
        logic signed [63:0] operand_a;
        logic signed [63:0] operand_b;
    } req_t;

    // response beat
    typedef struct packed {
        logic signed [63:0] result;
        logic               divide_by_zero;
    } rsp_t;

    // per-item data carried alongside the divider and multiplier
    typedef struct packed {
        op_t         op;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] simple;
        logic        bz;
        logic [63:0] quo;
    } side_t;

    // wrap to a w-bit word and sign extend back to 64 bits
    function automatic logic [63:0] wrap_word(input logic [63:0] x, input int unsigned w);
        logic signed [63:0] t;
        t = $signed(x << (64 - w));
        return 64'(t >>> (64 - w));
    endfunction

endpackage

// File: rtl/fixed_point_arith_unit.sv
`timescale 1ns / 1ps
// throughput: one request per cycle unless the response stalls; the whole pipeline advances together
// the divider takes 64 + FRAC_BITS restoring steps, one per stage, and sets the depth
// a stalled response freezes every stage and stalls the request side
// reset clears all valid bits and sets infinity_code to 0x7FFFFFFFFFFFFFFF

module fixed_point_arith_unit #(
    parameter int FRAC_BITS = 32,
    parameter int WORD_BITS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  fpa_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output fpa_pkg::rsp_t rsp,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready
);
    import fpa_pkg::*;

    localparam logic [63:0] FRAC_MASK = (64'(1) << FRAC_BITS) - 64'(1);

    logic        adv;
    logic [62:0] inf_reg;

    logic        f_vld, f_neg;
    side_t       f_side;
    logic [63:0] f_ma, f_mb;

    logic        d_vld, d_neg;
    side_t       d_side;
    logic [63:0] d_quot;

    logic        p_vld_reg;
    side_t       p_side_reg;
    side_t       p_side_next;
    logic [63:0] p_x_reg, p_y_reg;
    logic [63:0] q_signed, inf_signed, divres;

    logic        m_vld;
    logic [63:0] m_prod;
    side_t       m_side;

    logic        rsp_valid_reg;
    rsp_t        rsp_reg;
    op_t         fin_op_reg;
    logic [63:0] fin_val;
    logic        fin_dz;

    // global advance
    assign adv       = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !adv;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[3] == 1'b0) ? {1'b0, inf_reg} : 64'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inf_reg <= '1;
        else if (psel && penable && pwrite && pready && (paddr[3] == 1'b0))
            inf_reg <= pwdata[62:0];
    end

    fpa_front #(
        .FRAC_BITS (FRAC_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (req_valid),
        .req     (req),
        .out_vld (f_vld),
        .side    (f_side),
        .ma      (f_ma),
        .mb      (f_mb),
        .neg_q   (f_neg)
    );

    fpa_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (f_vld),
        .in_side  (f_side),
        .ma       (f_ma),
        .mb       (f_mb),
        .neg_q    (f_neg),
        .out_vld  (d_vld),
        .out_side (d_side),
        .quot     (d_quot),
        .out_neg  (d_neg)
    );

    // quotient sign, zero divisor, multiplier operand select
    always_comb
    begin
        q_signed   = wrap_word(d_neg ? 64'd0 - d_quot : d_quot, WORD_BITS);
        inf_signed = wrap_word(d_side.a[63] ? 64'd0 - {1'b0, inf_reg} : {1'b0, inf_reg},
                               WORD_BITS);
        divres     = d_side.bz ? inf_signed : q_signed;
        p_side_next     = d_side;
        p_side_next.quo = divres;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_vld_reg <= 1'b0;
        else if (adv)
            p_vld_reg <= d_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_side_reg     <= p_side_next;
            p_x_reg        <= (d_side.op == OP_MUL) ? d_side.a : (divres & ~FRAC_MASK);
            p_y_reg        <= d_side.b;
        end
    end

    fpa_mul #(
        .FRAC_BITS (FRAC_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (p_vld_reg),
        .x        (p_x_reg),
        .y        (p_y_reg),
        .in_side  (p_side_reg),
        .out_vld  (m_vld),
        .prod     (m_prod),
        .out_side (m_side)
    );

    // final result select
    always_comb
    begin
        case (m_side.op)
            OP_MUL:  fin_val = m_prod;
            OP_DIV:  fin_val = m_side.quo;
            OP_IDIV: fin_val = m_side.quo & ~FRAC_MASK;
            OP_MOD:  fin_val = m_side.a - m_prod;
            default: fin_val = m_side.simple;
        endcase
        fin_dz = m_side.bz && ((m_side.op == OP_DIV) || (m_side.op == OP_IDIV)
                               || (m_side.op == OP_MOD));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (adv)
            rsp_valid_reg <= m_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rsp_reg.result         <= wrap_word(fin_val, WORD_BITS);
            rsp_reg.divide_by_zero <= fin_dz;
            fin_op_reg             <= m_side.op;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // checks
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall == (rsp_valid && rsp_stall))
        else $error("request stall does not follow a held response");

    a_dz_op: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.divide_by_zero |->
            (fin_op_reg == OP_DIV) || (fin_op_reg == OP_IDIV) || (fin_op_reg == OP_MOD))
        else $error("divide by zero flag on a non-divide operation");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> f_vld)
        else $error("accepted request missing from front stage");

endmodule

// File: rtl/fpa_front.sv
`timescale 1ns / 1ps

module fpa_front #(
    parameter int FRAC_BITS = 32,
    parameter int WORD_BITS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_vld,
    input  fpa_pkg::req_t req,
    output logic          out_vld,
    output fpa_pkg::side_t side,
    output logic [63:0]   ma,
    output logic [63:0]   mb,
    output logic          neg_q
);
    import fpa_pkg::*;

    localparam logic [63:0] ONE       = 64'(1) << FRAC_BITS;
    localparam logic [63:0] FRAC_MASK = ONE - 64'(1);

    logic [63:0] a, b, fl, simple;
    op_t         op;

    logic        vld_reg;
    side_t       side_reg;
    logic [63:0] ma_reg, mb_reg;
    logic        neg_reg;

    // operand wrap and the simple operations computed in the front stage
    always_comb
    begin
        a  = wrap_word(req.operand_a, WORD_BITS);
        b  = wrap_word(req.operand_b, WORD_BITS);
        op = op_t'(req.req_type);
        fl = a & ~FRAC_MASK;
        case (op)
            OP_ADD:   simple = a + b;
            OP_SUB:   simple = a - b;
            OP_FLOOR: simple = fl;
            OP_CEIL:  simple = fl + (((a & FRAC_MASK) != 64'd0) ? ONE : 64'd0);
            OP_ROUND: simple = wrap_word(a + (ONE >> 1), WORD_BITS) & ~FRAC_MASK;
            OP_ABS:   simple = a[63] ? 64'd0 - a : a;
            OP_NEG:   simple = 64'd0 - a;
            OP_SIGN:  simple = a[63] ? 64'd0 - ONE : ONE;
            default:  simple = 64'd0;
        endcase
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (adv)
            vld_reg <= in_vld;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg.op     <= op;
            side_reg.a      <= a;
            side_reg.b      <= b;
            side_reg.simple <= simple;
            side_reg.bz     <= (b == 64'd0);
            side_reg.quo    <= 64'd0;
            ma_reg          <= a[63] ? 64'd0 - a : a;
            mb_reg          <= b[63] ? 64'd0 - b : b;
            neg_reg         <= a[63] ^ b[63];
        end
    end

    assign out_vld = vld_reg;
    assign side    = side_reg;
    assign ma      = ma_reg;
    assign mb      = mb_reg;
    assign neg_q   = neg_reg;

endmodule

// File: rtl/fpa_divider.sv
`timescale 1ns / 1ps

module fpa_divider #(
    parameter int FRAC_BITS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_vld,
    input  fpa_pkg::side_t in_side,
    input  logic [63:0]    ma,
    input  logic [63:0]    mb,
    input  logic           neg_q,
    output logic           out_vld,
    output fpa_pkg::side_t out_side,
    output logic [63:0]    quot,
    output logic           out_neg
);
    import fpa_pkg::*;

    // dividend bits above this position are always zero
    localparam int STEPS = 64 + FRAC_BITS;
    localparam int NQ_W  = 64 + FRAC_BITS;

    logic [STEPS-1:0] vld_reg;
    logic [63:0]      rem_reg  [STEPS];
    logic [NQ_W-1:0]  nq_reg   [STEPS];
    logic [63:0]      mb_reg   [STEPS];
    logic [STEPS-1:0] neg_reg;
    side_t            side_reg [STEPS];

    // one restoring step per stage: dividend shifts out the top, quotient in the bottom
    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic [63:0]     rem_in, mb_in;
        logic [NQ_W-1:0] nq_in;
        logic            vld_in, neg_in;
        side_t           side_in;
        logic [64:0]     trial, diff;
        logic            fits;

        if (k == 0)
        begin : g_first
            assign rem_in  = 64'd0;
            assign nq_in   = {ma, {FRAC_BITS{1'b0}}};
            assign mb_in   = mb;
            assign vld_in  = in_vld;
            assign neg_in  = neg_q;
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign nq_in   = nq_reg[k-1];
            assign mb_in   = mb_reg[k-1];
            assign vld_in  = vld_reg[k-1];
            assign neg_in  = neg_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign trial = {rem_in, nq_in[NQ_W-1]};
        assign diff  = trial - {1'b0, mb_in};
        assign fits  = (trial >= {1'b0, mb_in});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (adv)
                vld_reg[k] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]  <= fits ? diff[63:0] : trial[63:0];
                nq_reg[k]   <= {nq_in[NQ_W-2:0], fits};
                mb_reg[k]   <= mb_in;
                neg_reg[k]  <= neg_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_vld  = vld_reg[STEPS-1];
    assign out_side = side_reg[STEPS-1];
    assign quot     = nq_reg[STEPS-1][63:0];
    assign out_neg  = neg_reg[STEPS-1];

endmodule

// File: rtl/fpa_mul.sv
`timescale 1ns / 1ps

module fpa_mul #(
    parameter int FRAC_BITS = 32,
    parameter int WORD_BITS = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_vld,
    input  logic [63:0]    x,
    input  logic [63:0]    y,
    input  fpa_pkg::side_t in_side,
    output logic           out_vld,
    output logic [63:0]    prod,
    output fpa_pkg::side_t out_side
);
    import fpa_pkg::*;

    localparam int NST = 4;

    logic [NST-1:0] vld_reg;
    side_t          side_reg [NST];
    logic [NST-2:0] neg_reg;
    logic [63:0]    mx_reg, my_reg;
    logic [63:0]    ll_reg, lh_reg, hl_reg, hh_reg;
    logic [127:0]   sum_reg;
    logic [63:0]    prod_reg;
    logic [127:0]   sum_next, sgn_full;

    // partial product sum and signed shift
    always_comb
    begin
        sum_next = {hh_reg, ll_reg} + {32'd0, lh_reg, 32'd0} + {32'd0, hl_reg, 32'd0};
        sgn_full = neg_reg[2] ? 128'd0 - sum_reg : sum_reg;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NST-2:0], in_vld};
    end

    // magnitude, partial products, sum, sign and scale
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mx_reg      <= x[63] ? 64'd0 - x : x;
            my_reg      <= y[63] ? 64'd0 - y : y;
            neg_reg     <= {neg_reg[NST-3:0], x[63] ^ y[63]};
            side_reg[0] <= in_side;
            for (int i = 1; i < NST; i++)
                side_reg[i] <= side_reg[i-1];
            ll_reg      <= mx_reg[31:0]  * my_reg[31:0];
            lh_reg      <= mx_reg[31:0]  * my_reg[63:32];
            hl_reg      <= mx_reg[63:32] * my_reg[31:0];
            hh_reg      <= mx_reg[63:32] * my_reg[63:32];
            sum_reg     <= sum_next;
            prod_reg    <= wrap_word(64'(sgn_full >> FRAC_BITS), WORD_BITS);
        end
    end

    assign out_vld  = vld_reg[NST-1];
    assign prod     = prod_reg;
    assign out_side = side_reg[NST-1];

endmodule
